[rtl/ecu_pkg.sv]
// Shared types, constants and arithmetic helpers of the easing curve unit.
// Used by ecu_pipe and easing_curve_unit; depends on nothing else.
`default_nettype none
package ecu_pkg;

  localparam int FRAC_BITS = 15;
  localparam int PHASE_W   = 16;
  localparam int EASED_W   = 17;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 3;

  localparam logic [16:0] ONE = 17'(64'd1 << FRAC_BITS);

  // Back overshoot constants, and pi/2 and ln2 taken from Q32.
  localparam logic [16:0] C1 =
    17'((64'd170158 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic [16:0] C2 =
    17'((64'd259490950 * (64'd1 << FRAC_BITS) + 64'd50000000) / 64'd100000000);
  localparam logic [16:0] PIH =
    17'((64'd6746518852 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic [16:0] LN2C =
    17'((64'd2977044472 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  localparam logic [2:0] FAM_QUAD  = 3'd0;
  localparam logic [2:0] FAM_CUBIC = 3'd1;
  localparam logic [2:0] FAM_QUART = 3'd2;
  localparam logic [2:0] FAM_QUINT = 3'd3;
  localparam logic [2:0] FAM_BACK  = 3'd4;
  localparam logic [2:0] FAM_SINE  = 3'd5;
  localparam logic [2:0] FAM_EXPO  = 3'd6;
  localparam logic [2:0] FAM_CIRC  = 3'd7;

  localparam logic [1:0] DIR_IN    = 2'd0;
  localparam logic [1:0] DIR_OUT   = 2'd1;
  localparam logic [1:0] DIR_INOUT = 2'd2;

  localparam logic CFG_FAMILY    = 1'b0;
  localparam logic CFG_DIRECTION = 1'b1;

  // Pipeline layout.
  localparam int NS        = 24;
  localparam int HRN_FIRST = 3;
  localparam int HRN_STEPS = 10;
  localparam int SQ_FIRST  = 3;
  localparam int SQ_STAGES = 8;
  localparam int SQ_ROUND  = SQ_FIRST + SQ_STAGES;
  localparam int POST      = HRN_FIRST + 2 * HRN_STEPS;
  localparam int RCP_SHIFT = 25;

  localparam int unsigned EXP_DIV [HRN_STEPS] = '{10, 9, 8, 7, 6, 5, 4, 3, 2, 1};
  localparam int unsigned SIN_DIV [HRN_STEPS] = '{0, 0, 0, 0, 0, 110, 72, 42, 20, 6};

  typedef struct packed {
    logic [2:0] fam;
    logic [1:0] dir;
  } ecu_cfg_t;

  typedef struct packed {
    logic [2:0]         fam;
    logic [1:0]         dir;
    logic               hi;
    logic               zero;
    logic [15:0]        x;
    logic signed [18:0] pw;
    logic signed [18:0] bkb;
    logic [15:0]        sy;
    logic [16:0]        hop;
    logic [16:0]        hprod;
    logic [15:0]        acc;
    logic [3:0]         en;
    logic [31:0]        srad;
    logic [19:0]        srem;
    logic [15:0]        sroot;
    logic [15:0]        cres;
    logic [16:0]        tr;
  } ecu_stage_t;

  // Unsigned fixed-point product, rounded half up.
  function automatic logic [20:0] fmul_u(input logic [17:0] a, input logic [17:0] b);
    logic [35:0] p;
    p = a * b + (36'd1 << (FRAC_BITS - 1));
    return p[35:15];
  endfunction

endpackage
`default_nettype wire

[rtl/ecu_pipe.sv]
// Datapath pipeline of the easing curve unit: input stage, polynomial, sine and
// exponential Horner chain, square root and direction/saturation output stage.
// Depends on ecu_pkg.
`default_nettype none
module ecu_pipe import ecu_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ecu_cfg_t             cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PHASE_W-1:0]   phase_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [EASED_W-1:0]        eased_o
);

  ecu_stage_t stg_q [NS];
  ecu_stage_t stg_d [NS];
  logic [NS:0] vld_q;
  logic [NS:0] rdy;
  logic [EASED_W-1:0] res_q, res_d;

  assign rdy[NS] = !vld_q[NS] || out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_comb begin
    logic [16:0] t;
    stg_d[0] = '0;
    t = ({1'b0, phase_i} > ONE) ? ONE : {1'b0, phase_i};
    stg_d[0].fam = cfg_i.fam;
    stg_d[0].dir = cfg_i.dir;
    case (cfg_i.dir)
      DIR_OUT: begin
        stg_d[0].x = 16'(ONE - t);
      end
      DIR_INOUT: begin
        if (t < (ONE >> 1)) begin
          stg_d[0].x = 16'(t << 1);
        end else begin
          stg_d[0].x  = 16'((ONE << 1) - (t << 1));
          stg_d[0].hi = 1'b1;
        end
      end
      default: begin
        stg_d[0].x = t[15:0];
      end
    endcase
  end

  for (genvar i = 1; i < NS; i++) begin : g_stage
    localparam int J  = (i - HRN_FIRST) / 2;
    localparam int JC = (J < 0) ? 0 : ((J > HRN_STEPS - 1) ? HRN_STEPS - 1 : J);
    localparam bit IS_MUL = (((i - HRN_FIRST) % 2) == 0);
    localparam int unsigned DE = EXP_DIV[JC];
    localparam int unsigned DS = (SIN_DIV[JC] == 0) ? 1 : SIN_DIV[JC];
    localparam logic [25:0] RE = 26'(((64'd1 << RCP_SHIFT) + 64'(DE) - 64'd1) / 64'(DE));
    localparam logic [25:0] RS = 26'(((64'd1 << RCP_SHIFT) + 64'(DS) - 64'd1) / 64'(DS));
    localparam logic [6:0]  HE = 7'(DE / 2);
    localparam logic [6:0]  HS = 7'(DS / 2);

    always_comb begin
      ecu_stage_t  c;
      logic [20:0] m;
      logic [20:0] m2;
      logic [16:0] cb;
      logic [17:0] cbp1;
      logic [16:0] d;
      logic [19:0] u;
      logic [18:0] mag;
      logic        hact;
      logic [42:0] qp;
      logic [17:0] q;
      logic [17:0] na;
      logic [19:0] rm;
      logic [17:0] tt;
      logic [16:0] w;
      logic [15:0] rt;
      logic [16:0] r;
      logic [16:0] sh;
      logic [16:0] sres;
      logic [16:0] eres;
      c = stg_q[i-1];
      m = '0;
      m2 = '0;
      cb = '0;
      cbp1 = '0;
      d = '0;
      u = '0;
      mag = '0;
      qp = '0;
      q = '0;
      na = '0;
      rm = '0;
      tt = '0;
      w = '0;
      rt = '0;
      r = '0;
      sh = '0;
      sres = '0;
      eres = '0;
      hact = (c.fam == FAM_EXPO) || ((c.fam == FAM_SINE) && (SIN_DIV[JC] != 0));

      if (i == 1) begin
        cb   = (c.dir == DIR_INOUT) ? C2 : C1;
        cbp1 = {1'b0, cb} + {1'b0, ONE};
        m    = fmul_u({2'b0, c.x}, {2'b0, c.x});
        c.pw = 19'(m);
        m2   = fmul_u(cbp1, {2'b0, c.x});
        c.bkb = $signed({1'b0, m2[17:0]}) - $signed({2'b0, cb});
        d    = ONE - {1'b0, c.x};
        m    = fmul_u({1'b0, d}, {1'b0, PIH});
        c.sy = m[15:0];
        c.zero = (c.x == 16'd0);
        u    = ({3'b0, d} << 3) + ({3'b0, d} << 1);
        c.en = u[18:15];
        m    = fmul_u({3'b0, u[14:0]}, {1'b0, LN2C});
        c.hop = m[16:0];
      end

      if (i == 2) begin
        w      = ONE - 17'(stg_q[i-1].pw);
        c.srad = 32'(w) << FRAC_BITS;
        c.srem = '0;
        c.sroot = '0;
        c.acc  = ONE[15:0];
        if (c.fam == FAM_SINE) begin
          m = fmul_u({2'b0, c.sy}, {2'b0, c.sy});
          c.hop = m[16:0];
        end
        if (c.fam == FAM_BACK) begin
          mag  = c.bkb[18] ? 19'(-c.bkb) : 19'(c.bkb);
          m    = fmul_u(18'(c.pw), mag[17:0]);
          c.pw = c.bkb[18] ? -19'(m) : 19'(m);
        end
      end

      if (i >= 2 && i <= 4) begin
        if (c.fam <= FAM_QUINT && c.fam >= 3'(i - 1)) begin
          m    = fmul_u(18'(c.pw), {2'b0, c.x});
          c.pw = 19'(m);
        end
      end

      if (i >= HRN_FIRST && i < POST && hact) begin
        if (IS_MUL) begin
          m = fmul_u({1'b0, c.hop}, {2'b0, c.acc});
          c.hprod = m[16:0];
        end else if (c.fam == FAM_SINE) begin
          qp = (43'(c.hprod) + 43'(HS)) * 43'(RS);
          q  = qp[42:RCP_SHIFT];
          na = {1'b0, ONE} - q;
          c.acc = na[15:0];
        end else begin
          qp = (43'(c.hprod) + 43'(HE)) * 43'(RE);
          q  = qp[42:RCP_SHIFT];
          na = {1'b0, ONE} - q;
          c.acc = na[15:0];
        end
      end

      if (i >= SQ_FIRST && i < SQ_ROUND) begin
        for (int k = 0; k < 2; k++) begin
          rm = {c.srem[17:0], c.srad[31:30]};
          c.srad = c.srad << 2;
          tt = {c.sroot, 2'b01};
          if (rm >= 20'(tt)) begin
            rm = rm - 20'(tt);
            c.sroot = {c.sroot[14:0], 1'b1};
          end else begin
            c.sroot = {c.sroot[14:0], 1'b0};
          end
          c.srem = rm;
        end
      end

      if (i == SQ_ROUND) begin
        rt = (c.srem > 20'(c.sroot)) ? c.sroot + 16'd1 : c.sroot;
        c.cres = 16'(ONE - 17'(rt));
      end

      if (i == POST) begin
        m    = fmul_u({2'b0, c.sy}, {2'b0, c.acc});
        r    = (m > 21'(ONE)) ? ONE : m[16:0];
        if (c.zero) begin
          r = ONE;
        end
        sres = ONE - r;
        sh   = {c.acc, 1'b0} >> c.en;
        eres = c.zero ? 17'd0 : ((sh + 17'd1) >> 1);
        c.tr = (c.fam == FAM_SINE) ? sres : eres;
      end

      stg_d[i] = c;
    end
  end

  always_comb begin
    ecu_stage_t         c;
    logic signed [19:0] e;
    logic signed [19:0] h;
    logic signed [19:0] v;
    logic signed [19:0] one_s;
    logic [19:0]        mag;
    logic [18:0]        hm;
    c = stg_q[NS-1];
    one_s = $signed({3'b0, ONE});
    case (c.fam) inside
      FAM_SINE, FAM_EXPO: e = $signed({3'b0, c.tr});
      FAM_CIRC:           e = $signed({4'b0, c.cres});
      default:            e = {c.pw[18], c.pw};
    endcase
    mag = e[19] ? 20'(-e) : 20'(e);
    hm  = 19'((mag + 20'd1) >> 1);
    h   = e[19] ? -$signed({1'b0, hm}) : $signed({1'b0, hm});
    case (c.dir)
      DIR_OUT:   v = one_s - e;
      DIR_INOUT: v = c.hi ? one_s - h : h;
      default:   v = e;
    endcase
    if (v > 20'sd65535) begin
      res_d = 17'h0FFFF;
    end else if (v < -20'sd65536) begin
      res_d = 17'h10000;
    end else begin
      res_d = v[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS];
  assign eased_o     = res_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && rdy[0] |=> vld_q[0])
    else $error("accepted transaction did not enter the first stage");

  a_horner_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[POST-1] |-> stg_q[POST-1].acc <= ONE[15:0])
    else $error("series accumulator exceeds one");

  a_power_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS] && stg_q[NS-1].fam <= FAM_QUINT && rdy[NS] && vld_q[NS-1]
    |=> !res_q[16] && res_q <= ONE)
    else $error("power curve result outside zero to one");

  a_root_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_ROUND-1] |-> stg_q[SQ_ROUND-1].srad == 32'd0)
    else $error("square root operand not fully consumed");

endmodule
`default_nettype wire

[rtl/easing_curve_unit.sv]
// Top level of the easing curve unit: stream ports, configuration registers.
// Depends on ecu_pkg and ecu_pipe.
//
//  channel     dir  signals                               contents
//  s_axis      in   s_axis_tvalid/tready/tdata[15:0]      phase
//  m_axis      out  m_axis_tvalid/tready/tdata[23:0]      eased (17 bits, zero filled)
//  cfg         in   cfg_we_i, cfg_idx_i, cfg_wdata_i[2:0]  curve_family, curve_direction
//
// One transaction is accepted per clock unless stalled; it passes through the
// 24-stage datapath and output register, a depth set by the 10-step Horner chain.
// Reset clears the stage valid bits and both registers (quad, ease in).
// A stalled output holds its transaction; upstream stages keep filling bubbles.
`default_nettype none
module easing_curve_unit import ecu_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [PHASE_W-1:0]      s_axis_tdata,   // [15:0] phase
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata    // [16:0] eased
);

  ecu_cfg_t cfg_q;
  logic [EASED_W-1:0] eased;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fam <= FAM_QUAD;
      cfg_q.dir <= DIR_IN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAMILY:    cfg_q.fam <= cfg_wdata_i[2:0];
        CFG_DIRECTION: cfg_q.dir <= cfg_wdata_i[1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  ecu_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .phase_i     (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .eased_o     (eased)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - EASED_W){1'b0}}, eased};

endmodule
`default_nettype wire
